@@ rtl/core/thp_pkg.sv @@
// Shared types, register codes and shift helpers for the sensor compensation block.
// No dependencies; every module of the block imports this package.
package thp_pkg;

	typedef struct packed {
		logic [19:0] raw_pressure;
		logic [19:0] raw_temperature;
		logic [15:0] raw_humidity;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] temperature_centideg;
		logic [31:0]        pressure_pascal;
		logic [14:0]        humidity_rh256;
		logic               pressure_invalid;
	} out_item_t;

	typedef struct packed {
		logic [47:0] temp;
		logic [63:0] press_a;
		logic [63:0] press_b;
		logic [15:0] press_c;
		logic [63:0] hum;
	} cal_t;

	localparam int CfgIdxW = 3;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_TEMP    = 3'd0,
		CFG_PRESS_A = 3'd1,
		CFG_PRESS_B = 3'd2,
		CFG_PRESS_C = 3'd3,
		CFG_HUM     = 3'd4
	} cfg_idx_t;

	// sequencer steps of the back end
	typedef enum logic [4:0] {
		ST_IDLE, T_A, T_B, T_C,
		P_S, P_V2, P_V5, P_U, P_V2B, P_V1, P_D, P_DIV, P_Q9, P_Q9B, P_Q8,
		H_X, H_Y, H_Z, H_W, H_W2, H_V, H_SQ, H_H1, ST_OUT
	} step_t;

	localparam logic [31:0] HumClamp = 32'd419430400;

	function automatic logic [31:0] asr32(input logic [31:0] x, input logic [5:0] n);
		return $unsigned($signed(x) >>> n);
	endfunction

	function automatic logic [63:0] asr64(input logic [63:0] x, input logic [6:0] n);
		return $unsigned($signed(x) >>> n);
	endfunction

	function automatic logic [63:0] sx16(input logic [15:0] x);
		return {{48{x[15]}}, x};
	endfunction

endpackage

@@ rtl/core/thp_sensor_compensation.sv @@
// Top level of the pressure / temperature / humidity compensation block.
// Depends on thp_pkg, thp_front, thp_back (thp_mul, thp_div below it).
//
//  channel | signals                                  | dir
//  --------+------------------------------------------+-----
//  in      | in_valid, in_ready, in_item              | in
//  out     | out_valid, out_ready, out_item           | out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| in
//
// Per item the back end pops it from the queue, runs 21 products through the shared
// 32x32 multiplier (one start and three passes each) and one divide in the bit-serial
// divider, then hands off the result. With a zero pressure divisor the divide and four
// products are skipped.
// Reset clears the calibration registers, the queue and the sequencer.
// The two-entry input queue keeps taking items while the back end works,
// and the output register lets the next item start while a result waits.
module thp_sensor_compensation (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  thp_pkg::in_item_t      in_item,
	output logic                   out_valid,
	input  logic                   out_ready,
	output thp_pkg::out_item_t     out_item,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [2:0]             cfg_index,
	input  logic [63:0]            cfg_data
);
	import thp_pkg::*;

	cal_t     cal_q;
	logic     q_valid, q_pop;
	in_item_t q_item;

	// calibration writes are always taken; unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_TEMP:    cal_q.temp    <= cfg_data[47:0];
				CFG_PRESS_A: cal_q.press_a <= cfg_data;
				CFG_PRESS_B: cal_q.press_b <= cfg_data;
				CFG_PRESS_C: cal_q.press_c <= cfg_data[15:0];
				CFG_HUM:     cal_q.hum     <= cfg_data;
				default: ;
			endcase
		end
	end

	thp_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
	);

	thp_back u_back (
		.clk(clk), .arst_n(arst_n), .cal(cal_q),
		.q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);
endmodule

@@ rtl/core/thp_front.sv @@
// Front end: accepts input items into a two-entry queue for the back end.
// Depends on thp_pkg.
module thp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  thp_pkg::in_item_t in_item,
	output logic              q_valid,
	input  logic              q_pop,
	output thp_pkg::in_item_t q_item
);
	import thp_pkg::*;

	in_item_t   mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule

@@ rtl/core/thp_mul.sv @@
// Wrapping 64x64 multiply, low 64 bits, three passes through one 32x32 multiplier.
// Depends on thp_pkg.
module thp_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] p
);
	import thp_pkg::*;

	logic [63:0] a_q, b_q, acc_q;
	logic [1:0]  ph_q;
	logic        run_q;
	logic [31:0] ma, mb;
	logic [63:0] mp;

	always_comb begin
		case (ph_q)
			2'd1:    begin ma = a_q[63:32]; mb = b_q[31:0];  end
			2'd2:    begin ma = a_q[31:0];  mb = b_q[63:32]; end
			default: begin ma = a_q[31:0];  mb = b_q[31:0];  end
		endcase
	end
	assign mp   = ma * mb;
	assign p    = acc_q;
	assign done = run_q && (ph_q == 2'd3);

	always_ff @(posedge clk) begin
		if (go) begin
			a_q <= a;
			b_q <= b;
		end
		if (run_q) begin
			case (ph_q)
				2'd0:    acc_q <= mp;
				2'd1:    acc_q[63:32] <= acc_q[63:32] + mp[31:0];
				2'd2:    acc_q[63:32] <= acc_q[63:32] + mp[31:0];
				default: acc_q <= acc_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			ph_q  <= 2'd0;
		end else if (go) begin
			run_q <= 1'b1;
			ph_q  <= 2'd0;
		end else if (run_q) begin
			ph_q <= ph_q + 2'd1;
			if (ph_q == 2'd3) run_q <= 1'b0;
		end
	end
endmodule

@@ rtl/core/thp_div.sv @@
// Signed 64-bit divide truncating toward zero, one quotient bit per cycle.
// Depends on thp_pkg.
module thp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        done,
	output logic [63:0] quo
);
	import thp_pkg::*;

	logic [63:0] dvd_q, dsr_q;
	logic [63:0] rem_q;
	logic [64:0] rem_sh;
	logic        neg_q, run_q;
	logic [6:0]  cnt_q;
	logic        ge;

	assign rem_sh = {rem_q, dvd_q[63]};
	assign ge     = rem_sh >= {1'b0, dsr_q};
	assign done   = run_q && (cnt_q == 7'd64);
	assign quo    = neg_q ? 64'd0 - dvd_q : dvd_q;

	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= dividend[63] ? 64'd0 - dividend : dividend;
			dsr_q <= divisor[63] ? 64'd0 - divisor : divisor;
			neg_q <= dividend[63] ^ divisor[63];
			rem_q <= '0;
		end else if (run_q && cnt_q != 7'd64) begin
			rem_q <= ge ? rem_sh[63:0] - dsr_q : rem_sh[63:0];
			dvd_q <= {dvd_q[62:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= 7'd0;
		end else if (go) begin
			run_q <= 1'b1;
			cnt_q <= 7'd0;
		end else if (run_q) begin
			if (cnt_q == 7'd64) run_q <= 1'b0;
			else cnt_q <= cnt_q + 7'd1;
		end
	end
endmodule

@@ rtl/core/thp_back.sv @@
// Back end: step sequencer over the shared multiplier and divider, plus output register.
// Depends on thp_pkg, thp_mul, thp_div.
module thp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  thp_pkg::cal_t      cal,
	input  logic               q_valid,
	output logic               q_pop,
	input  thp_pkg::in_item_t  q_item,
	output logic               out_valid,
	input  logic               out_ready,
	output thp_pkg::out_item_t out_item
);
	import thp_pkg::*;

	step_t       st_q, st_d;
	in_item_t    cur_q;
	out_item_t   out_q;
	logic        ov_q, busy_q, inv_q;
	logic [31:0] fine_q, hx_q, press_q;
	logic [14:0] hum_q;
	logic [63:0] rs_q, rt_q, rv2_q, ra_q, q_q;

	logic        mul_go, mul_done, div_go, div_done, is_mul;
	logic [63:0] mul_a, mul_b, mul_p, quo;
	logic [63:0] v1c, pp, pf, pf8;
	logic [31:0] hv, p32, ta, tb, hfin, temp, fine5;

	// calibration fields
	logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
	assign t1 = {16'd0, cal.temp[15:0]};
	assign t2 = {{16{cal.temp[31]}}, cal.temp[31:16]};
	assign t3 = {{16{cal.temp[47]}}, cal.temp[47:32]};
	assign h1 = {24'd0, cal.hum[7:0]};
	assign h2 = {{16{cal.hum[23]}}, cal.hum[23:8]};
	assign h3 = {24'd0, cal.hum[31:24]};
	assign h4 = {20'd0, cal.hum[43:32]};
	assign h5 = {20'd0, cal.hum[55:44]};
	assign h6 = {{24{cal.hum[63]}}, cal.hum[63:56]};

	assign ta  = {15'd0, cur_q.raw_temperature[19:3]} - (t1 << 1);
	assign tb  = {16'd0, cur_q.raw_temperature[19:4]} - t1;
	assign v1c = {{32{fine_q[31]}}, fine_q} - 64'd128000;
	assign pp  = 64'd1048576 - {44'd0, cur_q.raw_pressure};
	assign hv  = fine_q - 32'd76800;
	assign p32 = mul_p[31:0];
	assign pf  = asr64(q_q + rt_q + asr64(mul_p, 7'd19), 7'd8)
		+ (sx16(cal.press_b[47:32]) << 4);
	assign pf8 = asr64(pf, 7'd8);
	assign hfin = rt_q[31:0] - asr32(p32, 6'd4);
	assign fine5 = fine_q + (fine_q << 2) + 32'd128;
	assign temp  = asr32(fine5, 6'd8);

	thp_mul u_mul (
		.clk(clk), .arst_n(arst_n), .go(mul_go), .a(mul_a), .b(mul_b),
		.done(mul_done), .p(mul_p)
	);
	thp_div u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .dividend(rt_q), .divisor(ra_q),
		.done(div_done), .quo(quo)
	);

	// next step
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (q_valid) st_d = T_A;
			T_A:     if (mul_done) st_d = T_B;
			T_B:     if (mul_done) st_d = T_C;
			T_C:     if (mul_done) st_d = P_S;
			P_S:     if (mul_done) st_d = P_V2;
			P_V2:    if (mul_done) st_d = P_V5;
			P_V5:    if (mul_done) st_d = P_U;
			P_U:     if (mul_done) st_d = P_V2B;
			P_V2B:   if (mul_done) st_d = P_V1;
			P_V1:    if (mul_done) st_d = (asr64(mul_p, 7'd33) == 64'd0) ? H_X : P_D;
			P_D:     if (mul_done) st_d = P_DIV;
			P_DIV:   if (div_done) st_d = P_Q9;
			P_Q9:    if (mul_done) st_d = P_Q9B;
			P_Q9B:   if (mul_done) st_d = P_Q8;
			P_Q8:    if (mul_done) st_d = H_X;
			H_X:     if (mul_done) st_d = H_Y;
			H_Y:     if (mul_done) st_d = H_Z;
			H_Z:     if (mul_done) st_d = H_W;
			H_W:     if (mul_done) st_d = H_W2;
			H_W2:    if (mul_done) st_d = H_V;
			H_V:     if (mul_done) st_d = H_SQ;
			H_SQ:    if (mul_done) st_d = H_H1;
			H_H1:    if (mul_done) st_d = ST_OUT;
			ST_OUT:  if (!ov_q || out_ready) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// step outputs: multiplier operands and unit starts
	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		is_mul = 1'b1;
		case (st_q)
			T_A:   begin mul_a = {32'd0, ta}; mul_b = {32'd0, t2}; end
			T_B:   begin mul_a = {32'd0, tb}; mul_b = {32'd0, tb}; end
			T_C:   begin mul_a = rs_q; mul_b = {32'd0, t3}; end
			P_S:   begin mul_a = v1c; mul_b = v1c; end
			P_V2:  begin mul_a = rs_q; mul_b = sx16(cal.press_b[31:16]); end
			P_V5:  begin mul_a = v1c; mul_b = sx16(cal.press_b[15:0]); end
			P_U:   begin mul_a = rs_q; mul_b = sx16(cal.press_a[47:32]); end
			P_V2B: begin mul_a = v1c; mul_b = sx16(cal.press_a[31:16]); end
			P_V1:  begin mul_a = (64'd1 << 47) + rt_q; mul_b = {48'd0, cal.press_a[15:0]}; end
			P_D:   begin mul_a = (pp << 31) - rv2_q; mul_b = 64'd3125; end
			P_Q9:  begin mul_a = sx16(cal.press_c); mul_b = asr64(q_q, 7'd13); end
			P_Q9B: begin mul_a = rs_q; mul_b = asr64(q_q, 7'd13); end
			P_Q8:  begin mul_a = sx16(cal.press_b[63:48]); mul_b = q_q; end
			H_X:   begin mul_a = {32'd0, h5}; mul_b = {32'd0, hv}; end
			H_Y:   begin mul_a = {32'd0, hv}; mul_b = {32'd0, h6}; end
			H_Z:   begin mul_a = {32'd0, hv}; mul_b = {32'd0, h3}; end
			H_W:   begin mul_a = rs_q; mul_b = rt_q; end
			H_W2:  begin mul_a = rs_q; mul_b = {32'd0, h2}; end
			H_V:   begin mul_a = {32'd0, hx_q}; mul_b = rs_q; end
			H_SQ:  begin
				mul_a = {32'd0, asr32(rt_q[31:0], 6'd15)};
				mul_b = {32'd0, asr32(rt_q[31:0], 6'd15)};
			end
			H_H1:  begin mul_a = rs_q; mul_b = {32'd0, h1}; end
			default: is_mul = 1'b0;
		endcase
	end
	assign mul_go = is_mul && !busy_q;
	assign div_go = (st_q == P_DIV) && !busy_q;
	assign q_pop  = (st_q == ST_IDLE) && q_valid;

	assign out_valid = ov_q;
	assign out_item  = out_q;

	always_ff @(posedge clk) begin
		if (q_pop) cur_q <= q_item;
		if (mul_done) begin
			case (st_q)
				T_A:   rt_q <= {32'd0, asr32(p32, 6'd11)};
				T_B:   rs_q <= {32'd0, asr32(p32, 6'd12)};
				T_C:   fine_q <= rt_q[31:0] + asr32(p32, 6'd14);
				P_S:   rs_q <= mul_p;
				P_V2:  rv2_q <= mul_p;
				P_V5:  rv2_q <= rv2_q + (mul_p << 17) + (sx16(cal.press_a[63:48]) << 35);
				P_U:   rt_q <= asr64(mul_p, 7'd8);
				P_V2B: rt_q <= rt_q + (mul_p << 12);
				P_V1:  begin
					ra_q    <= asr64(mul_p, 7'd33);
					inv_q   <= (asr64(mul_p, 7'd33) == 64'd0);
					press_q <= '0;
				end
				P_D:   rt_q <= mul_p;
				P_Q9:  rs_q <= mul_p;
				P_Q9B: rt_q <= asr64(mul_p, 7'd25);
				P_Q8:  press_q <= pf8[31:0];
				H_X:   hx_q <= asr32({2'd0, cur_q.raw_humidity, 14'd0} - (h4 << 20)
					- p32 + 32'd16384, 6'd15);
				H_Y:   rs_q <= {32'd0, asr32(p32, 6'd10)};
				H_Z:   rt_q <= {32'd0, asr32(p32, 6'd11) + 32'd32768};
				H_W:   rs_q <= {32'd0, asr32(p32, 6'd10) + 32'd2097152};
				H_W2:  rs_q <= {32'd0, asr32(p32 + 32'd8192, 6'd14)};
				H_V:   rt_q <= {32'd0, p32};
				H_SQ:  rs_q <= {32'd0, asr32(p32, 6'd7)};
				H_H1:  begin
					if (hfin[31]) hum_q <= 15'd0;
					else if (hfin > HumClamp) hum_q <= HumClamp[28:14];
					else hum_q <= hfin[28:14];
				end
				default: ;
			endcase
		end
		if (div_done) q_q <= quo;
		if (st_q == ST_OUT && (!ov_q || out_ready)) begin
			out_q.temperature_centideg <= $signed(temp);
			out_q.pressure_pascal      <= press_q;
			out_q.humidity_rh256       <= hum_q;
			out_q.pressure_invalid     <= inv_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			busy_q <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			st_q <= st_d;
			if (mul_go || div_go) busy_q <= 1'b1;
			else if (mul_done || div_done) busy_q <= 1'b0;
			if (st_q == ST_OUT && (!ov_q || out_ready)) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

`ifndef ASSERT_OFF
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> st_q == ST_IDLE) else $error("queue pop outside idle");
	a_div_nz: assert property (@(posedge clk) disable iff (!arst_n)
		div_go |-> ra_q != 64'd0) else $error("divide by zero started");
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_go && div_go)) else $error("two units started at once");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(mul_go || div_go) |-> !busy_q) else $error("unit started while busy");
`endif
endmodule

@@ test/tb_thp_sensor_compensation.sv @@
// Testbench for thp_sensor_compensation: directed and random readings checked
// against an in-bench model of the integer compensation. Depends on thp_pkg and the RTL.
`timescale 1ns / 1ps

module tb_thp_sensor_compensation;
	import thp_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_item;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_item;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	thp_sensor_compensation dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// calibration copy held by the bench
	logic [47:0] k_temp;
	logic [63:0] k_pa, k_pb, k_hum;
	logic [15:0] k_pc;

	in_item_t  reading_q[$];
	out_item_t comp_q[$];

	int  errors = 0;
	int  sent = 0;
	int  got = 0;
	int  invalid_seen = 0;
	int  send_idle_pct = 33;
	int  recv_idle_pct = 66;
	bit  hold_send = 0;
	int  quiet_cycles = 0;

	localparam int QuietLimit = 20000;

	function automatic logic [31:0] sra32(logic [31:0] x, int n);
		return $unsigned($signed(x) >>> n);
	endfunction

	function automatic logic [63:0] sra64(logic [63:0] x, int n);
		return $unsigned($signed(x) >>> n);
	endfunction

	function automatic logic [63:0] quot64(logic [63:0] a, logic [63:0] b);
		logic [63:0] ua, ub, q;
		ua = a[63] ? -a : a;
		ub = b[63] ? -b : b;
		q = ua / ub;
		return (a[63] != b[63]) ? -q : q;
	endfunction

	// full compensation of one reading with the current calibration
	function automatic out_item_t compensate(in_item_t r);
		out_item_t o;
		logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
		logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [31:0] adc_t, adc_h, a, b, tv1, tv2, fine, v, x, y, z, w, sq;
		logic [63:0] v1, v2, p;
		adc_t = {12'd0, r.raw_temperature};
		adc_h = {16'd0, r.raw_humidity};
		t1 = {16'd0, k_temp[15:0]};
		t2 = {{16{k_temp[31]}}, k_temp[31:16]};
		t3 = {{16{k_temp[47]}}, k_temp[47:32]};
		p1 = {48'd0, k_pa[15:0]};
		p2 = {{48{k_pa[31]}}, k_pa[31:16]};
		p3 = {{48{k_pa[47]}}, k_pa[47:32]};
		p4 = {{48{k_pa[63]}}, k_pa[63:48]};
		p5 = {{48{k_pb[15]}}, k_pb[15:0]};
		p6 = {{48{k_pb[31]}}, k_pb[31:16]};
		p7 = {{48{k_pb[47]}}, k_pb[47:32]};
		p8 = {{48{k_pb[63]}}, k_pb[63:48]};
		p9 = {{48{k_pc[15]}}, k_pc};
		h1 = {24'd0, k_hum[7:0]};
		h2 = {{16{k_hum[23]}}, k_hum[23:8]};
		h3 = {24'd0, k_hum[31:24]};
		h4 = {20'd0, k_hum[43:32]};
		h5 = {20'd0, k_hum[55:44]};
		h6 = {{24{k_hum[63]}}, k_hum[63:56]};

		a = (adc_t >> 3) - (t1 << 1);
		tv1 = sra32(a * t2, 11);
		b = (adc_t >> 4) - t1;
		tv2 = sra32(sra32(b * b, 12) * t3, 14);
		fine = tv1 + tv2;
		o.temperature_centideg = sra32(fine * 32'd5 + 32'd128, 8);

		v1 = {{32{fine[31]}}, fine} - 64'd128000;
		v2 = v1 * v1 * p6;
		v2 += (v1 * p5) << 17;
		v2 += p4 << 35;
		v1 = sra64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
		v1 = sra64(((64'd1 << 47) + v1) * p1, 33);
		if (v1 == 64'd0) begin
			o.pressure_invalid = 1'b1;
			o.pressure_pascal = 32'd0;
		end else begin
			o.pressure_invalid = 1'b0;
			p = 64'd1048576 - {44'd0, r.raw_pressure};
			p = quot64(((p << 31) - v2) * 64'd3125, v1);
			v1 = sra64(p9 * sra64(p, 13) * sra64(p, 13), 25);
			v2 = sra64(p8 * p, 19);
			p = sra64(p + v1 + v2, 8) + (p7 << 4);
			p = sra64(p, 8);
			o.pressure_pascal = p[31:0];
		end

		v = fine - 32'd76800;
		x = (adc_h << 14) - (h4 << 20) - (h5 * v);
		x = sra32(x + 32'd16384, 15);
		y = sra32(v * h6, 10);
		z = sra32(v * h3, 11) + 32'd32768;
		w = sra32(y * z, 10) + 32'd2097152;
		w = sra32(w * h2 + 32'd8192, 14);
		v = x * w;
		sq = sra32(sra32(v, 15) * sra32(v, 15), 7);
		v -= sra32(sq * h1, 4);
		if (v[31])
			v = 32'd0;
		else if (v > HumClamp)
			v = HumClamp;
		o.humidity_rh256 = v[28:14];
		return o;
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// driver: pops the pending readings, holds valid until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
		end else begin
			if (in_valid && in_ready) begin
				comp_q.push_back(compensate(in_item));
				sent++;
			end
			if (!in_valid || in_ready) begin
				if (reading_q.size() > 0 && !hold_send &&
				    $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_item <= reading_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got++;
				if (comp_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, out_item);
					errors++;
				end else begin
					out_item_t e;
					e = comp_q.pop_front();
					if (out_item.pressure_invalid) invalid_seen++;
					if (e.temperature_centideg != out_item.temperature_centideg) begin
						$display("%0t: temperature expected %0d got %0d", $time,
							e.temperature_centideg, out_item.temperature_centideg);
						errors++;
					end
					if (e.pressure_pascal != out_item.pressure_pascal) begin
						$display("%0t: pressure expected %h got %h", $time,
							e.pressure_pascal, out_item.pressure_pascal);
						errors++;
					end
					if (e.humidity_rh256 != out_item.humidity_rh256) begin
						$display("%0t: humidity expected %0d got %0d", $time,
							e.humidity_rh256, out_item.humidity_rh256);
						errors++;
					end
					if (e.pressure_invalid != out_item.pressure_invalid) begin
						$display("%0t: invalid flag expected %b got %b", $time,
							e.pressure_invalid, out_item.pressure_invalid);
						errors++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog on handshake silence
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else if (reading_q.size() > 0 || comp_q.size() > 0 || in_valid || cfg_valid)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// register write, mirrored into the bench copy at acceptance
	task automatic write_cal(cfg_idx_t idx, logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_TEMP:    k_temp = val[47:0];
			CFG_PRESS_A: k_pa = val;
			CFG_PRESS_B: k_pb = val;
			CFG_PRESS_C: k_pc = val[15:0];
			CFG_HUM:     k_hum = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// wait until nothing is in flight (optionally nothing pending either)
	task automatic wait_quiet(bit all_sent);
		int clean;
		clean = 0;
		while (clean < 2) begin
			@(posedge clk);
			if (!in_valid && comp_q.size() == 0 && (!all_sent || reading_q.size() == 0))
				clean++;
			else
				clean = 0;
		end
	endtask

	task automatic drain();
		wait_quiet(1'b1);
		repeat (200) @(posedge clk);
	endtask

	// typical device calibration with a little jitter
	task automatic load_typical();
		write_cal(CFG_TEMP, 64'({16'(50 + $urandom_range(20)), 16'(26435), 16'(27504)}));
		write_cal(CFG_PRESS_A, {16'(2855), -16'sd10685, 16'(26435 + $urandom_range(9)),
			16'(36477)});
		write_cal(CFG_PRESS_B, {16'(-7000), 16'(15500), -16'sd7, 16'(140)});
		write_cal(CFG_PRESS_C, 64'd6000);
		write_cal(CFG_HUM, {8'(30), 12'(50), 12'(320), 8'(0), 16'(360), 8'(75)});
	endtask

	function automatic in_item_t plausible();
		in_item_t r;
		r.raw_pressure = 20'(250000 + $urandom_range(300000));
		r.raw_temperature = 20'(450000 + $urandom_range(200000));
		r.raw_humidity = 16'(20000 + $urandom_range(30000));
		return r;
	endfunction

	function automatic in_item_t any_reading();
		in_item_t r;
		r.raw_pressure = 20'($urandom);
		r.raw_temperature = 20'($urandom);
		r.raw_humidity = 16'($urandom);
		return r;
	endfunction

	task automatic random_phase(int n, int sidle, int ridle);
		send_idle_pct = sidle;
		recv_idle_pct = ridle;
		for (int i = 0; i < n; i++)
			reading_q.push_back(($urandom_range(3) != 0) ? plausible() : any_reading());
		// one pause in the middle until every result is back
		while (reading_q.size() > n / 2) @(posedge clk);
		hold_send = 1'b1;
		wait_quiet(1'b0);
		hold_send = 1'b0;
		drain();
	endtask

	initial begin
		in_item_t r;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		k_temp = '0; k_pa = '0; k_pb = '0; k_pc = '0; k_hum = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all-zero calibration: divisor is zero, pressure flagged invalid
		r = '0; reading_q.push_back(r);
		r = '1; reading_q.push_back(r);
		drain();

		load_typical();
		// field extremes and a typical reading
		r = '0; reading_q.push_back(r);
		r = '1; reading_q.push_back(r);
		r.raw_pressure = 20'd415148; r.raw_temperature = 20'd519888;
		r.raw_humidity = 16'd31000; reading_q.push_back(r);
		r.raw_pressure = '0; r.raw_temperature = 20'hFFFFF; r.raw_humidity = 16'hFFFF;
		reading_q.push_back(r);
		r.raw_pressure = 20'hFFFFF; r.raw_temperature = '0; r.raw_humidity = '0;
		reading_q.push_back(r);
		// humidity pushed toward the clamp and toward negative
		r = plausible(); r.raw_humidity = 16'hFFFF; reading_q.push_back(r);
		r = plausible(); r.raw_humidity = 16'd0; reading_q.push_back(r);
		drain();

		// extreme coefficients: overflow paths and the divide corner cases
		write_cal(CFG_TEMP, 64'h0000_FFFF_7FFF_8000);
		write_cal(CFG_PRESS_A, 64'h8000_7FFF_8000_FFFF);
		write_cal(CFG_PRESS_B, 64'h7FFF_8000_7FFF_8000);
		write_cal(CFG_PRESS_C, 64'h0000_0000_0000_8000);
		write_cal(CFG_HUM, 64'h80FF_FFFF_FF7F_FFFF);
		for (int i = 0; i < 6; i++) reading_q.push_back(any_reading());
		r = '0; reading_q.push_back(r);
		r = '1; reading_q.push_back(r);
		drain();
		write_cal(CFG_PRESS_A, 64'h0);
		reading_q.push_back(plausible());
		drain();

		load_typical();
		random_phase(250, 33, 66);
		// fully random calibration in between
		write_cal(CFG_TEMP, {$urandom, $urandom});
		write_cal(CFG_PRESS_A, {$urandom, $urandom});
		write_cal(CFG_PRESS_B, {$urandom, $urandom});
		write_cal(CFG_PRESS_C, 64'($urandom));
		write_cal(CFG_HUM, {$urandom, $urandom});
		random_phase(100, 33, 66);
		load_typical();
		random_phase(250, 66, 33);
		load_typical();
		random_phase(250, 0, 0);

		$display("Covered %0d readings, %0d results, %0d with the invalid-pressure flag,",
			sent, got, invalid_seen);
		$display("over zero, typical, extreme and random calibrations with varied stalls.");
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
